// File: src/jch_pkg.sv
// Shared types and constants for the jump consistent hash block.
// No dependencies; imported by every module in src.
package jch_pkg;

    localparam int KEY_W     = 64;
    localparam int HALF_W    = 32;
    localparam int CNT_W     = 17;
    localparam int BKT_W     = 16;
    localparam int FRAC_SH   = 31;
    localparam int KEY_SH    = 33;
    localparam int NUM_W     = CNT_W + FRAC_SH;
    localparam int DEN_W     = 32;
    localparam int OUT_TDATA_W = ((BKT_W + 1 + 7) / 8) * 8;
    localparam int MAX_BUCKETS_DEF = 65536;

    localparam logic [KEY_W-1:0]  LCG_MUL    = 64'd2862933555777941757;
    localparam logic [HALF_W-1:0] LCG_MUL_LO = LCG_MUL[HALF_W-1:0];
    localparam logic [HALF_W-1:0] LCG_MUL_HI = LCG_MUL[KEY_W-1:HALF_W];
    localparam logic [CNT_W-1:0]  CFG_RESET  = 17'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// File: src/jch_lcg.sv
// Linear congruential key step (key * LCG_MUL + 1 mod 2^64).
// Uses one shared 32x32 multiplier for its three partial products; depends on jch_pkg.
module jch_lcg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [jch_pkg::KEY_W-1:0]   i_key,
    output logic [jch_pkg::KEY_W-1:0]   o_key,
    output jch_pkg::t_unit_stat         o_stat
);
    import jch_pkg::*;

    logic              r_run;
    logic              r_done;
    logic [1:0]        r_cnt;
    logic [HALF_W-1:0] r_kl;
    logic [HALF_W-1:0] r_kh;
    logic [KEY_W-1:0]  r_prod;
    logic [KEY_W-1:0]  r_acc;
    logic [HALF_W-1:0] w_opa;
    logic [HALF_W-1:0] w_opb;
    logic [KEY_W-1:0]  n_prod;

    always_comb begin
        w_opa  = (r_cnt == 2'd2) ? r_kh : r_kl;
        w_opb  = (r_cnt == 2'd1) ? LCG_MUL_HI : LCG_MUL_LO;
        n_prod = {{HALF_W{1'b0}}, w_opa} * {{HALF_W{1'b0}}, w_opb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 2'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kl <= i_key[HALF_W-1:0];
            r_kh <= i_key[KEY_W-1:HALF_W];
        end else if (r_run) begin
            if (r_cnt != 2'd3) begin
                r_prod <= n_prod;
            end
            case (r_cnt)
                2'd1:    r_acc <= r_prod + 64'd1;
                2'd2,
                2'd3:    r_acc[KEY_W-1:HALF_W] <= r_acc[KEY_W-1:HALF_W] + r_prod[HALF_W-1:0];
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_key       = r_acc;
    assign o_stat.busy = r_run;
    assign o_stat.done = r_done;

endmodule

// File: src/jch_div.sv
// Restoring divider, one quotient bit per cycle over NUM_W quotient bits.
// Depends on jch_pkg.
module jch_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [jch_pkg::NUM_W-1:0]   i_num,
    input  logic [jch_pkg::DEN_W-1:0]   i_den,
    output logic [jch_pkg::NUM_W-1:0]   o_quo,
    output jch_pkg::t_unit_stat         o_stat
);
    import jch_pkg::*;

    localparam int STEP_W = $clog2(NUM_W);

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_run;
    assign o_stat.done = r_done;

endmodule

// File: src/jump_consistent_hash.sv
// Jump consistent hash: maps a 64-bit key to a bucket below num_buckets.
// Each jump pass runs the shared LCG multiplier (4 steps, then done) and then the
// serial divider (48 steps, then done); a key needs about ln(num_buckets)+1 passes.
// One key at a time: a new key is taken only in idle, after the last result is loaded
// into a free output register, so an unaccepted output holds the block; no buckets: no pass.
// Synchronous active-low reset clears control, sets num_buckets to 1; uses jch_lcg, jch_div.
module jump_consistent_hash #(
    parameter int MAX_BUCKETS = jch_pkg::MAX_BUCKETS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [jch_pkg::CNT_W-1:0]         i_cfg_wdata,   // num_buckets
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [jch_pkg::KEY_W-1:0]         s_axis_tdata,  // [63:0] key
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [jch_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // [15:0] bucket, [16] valid_res
);
    import jch_pkg::*;

    localparam int CNT_LIM = (2 ** CNT_W) - 1;
    localparam int SAT_VAL = (MAX_BUCKETS > CNT_LIM) ? CNT_LIM : MAX_BUCKETS;
    localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(SAT_VAL);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_num_buckets;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_b;
    logic              r_res_valid;
    logic [KEY_W-1:0]  r_key;
    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [CNT_W-1:0]  w_count_sat;
    logic              w_accept;
    logic              w_out_free;
    logic              w_more;
    logic              w_mul_start;
    logic              w_div_start;
    logic              w_load_out;
    logic [KEY_W-1:0]  w_mul_key;
    logic [KEY_W-1:0]  w_lcg_key;
    logic [NUM_W-1:0]  w_num;
    logic [DEN_W-1:0]  w_den;
    logic [NUM_W-1:0]  w_quo;
    t_unit_stat        w_mul_stat;
    t_unit_stat        w_div_stat;

    assign w_count_sat = (r_num_buckets > COUNT_SAT) ? COUNT_SAT : r_num_buckets;
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_more      = (w_quo < {{(NUM_W-CNT_W){1'b0}}, r_count});
    assign w_mul_key   = (r_state == ST_IDLE) ? s_axis_tdata : r_key;
    assign w_num       = {r_b + CNT_W'(1), {FRAC_SH{1'b0}}};
    assign w_den       = {1'b0, w_lcg_key[KEY_W-1:KEY_SH]} + 32'd1;

    jch_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_key   (w_mul_key),
        .o_key   (w_lcg_key),
        .o_stat  (w_mul_stat)
    );

    jch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quo   (w_quo),
        .o_stat  (w_div_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_count_sat == '0) ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL: begin
                if (w_mul_stat.done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = w_more ? ST_MUL : ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_mul_start   = 1'b0;
        w_div_start   = 1'b0;
        w_load_out    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_mul_start   = s_axis_tvalid && (w_count_sat != '0);
            end
            ST_MUL: begin
                w_div_start = w_mul_stat.done;
            end
            ST_DIV: begin
                w_mul_start = w_div_stat.done && w_more;
            end
            ST_OUT: begin
                w_load_out = w_out_free;
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_num_buckets <= CFG_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_num_buckets <= i_cfg_wdata;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key       <= s_axis_tdata;
            r_count     <= w_count_sat;
            r_b         <= '0;
            r_res_valid <= (w_count_sat != '0);
        end else begin
            if ((r_state == ST_MUL) && w_mul_stat.done) begin
                r_key <= w_lcg_key;
            end
            if ((r_state == ST_DIV) && w_div_stat.done && w_more) begin
                r_b <= w_quo[CNT_W-1:0];
            end
        end
        if (w_load_out) begin
            r_out_data <= {{(OUT_TDATA_W-BKT_W-1){1'b0}}, r_res_valid, r_b[BKT_W-1:0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_stat.busy && w_div_stat.busy))
        else $error("multiplier and divider busy together");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide state");

    a_bucket_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_res_valid) |-> (r_b < r_count))
        else $error("chosen bucket not below bucket count");

    a_invalid_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && !r_res_valid) |-> (r_count == '0))
        else $error("no-bucket result with nonzero count");

endmodule
